// ===== rtl/opp_pkg.sv =====
package opp_pkg;

  // Command bytes of the page-addressing scheme
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] NIBBLE_HIGH   = 8'hF0;
  localparam logic [7:0] NIBBLE_LOW    = 8'h0F;

  // Column store entry: rows 0..6 of the current band
  localparam int ENTRY_W = 7;

  // Column offset register
  localparam int               OFFSET_W     = 7;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd2;

  // Result queue geometry
  localparam int MAX_RESULTS = 4;
  localparam int PUSH_W      = 3;
  localparam int OUT_DEPTH   = 8;
  localparam int OUT_PTR_W   = 3;
  localparam int OUT_CNT_W   = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic       frame_done;
  } result_t;

  // Results produced by one item in one cycle
  typedef struct packed {
    logic [PUSH_W-1:0]                num;
    result_t [MAX_RESULTS-1:0]        items;
  } push_t;

endpackage

// ===== rtl/opp_result_fifo.sv =====
module opp_result_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  opp_pkg::push_t                  push_i,
  input  logic                            pop_i,
  output opp_pkg::result_t                head_o,
  output logic                            not_empty_o,
  output logic [opp_pkg::OUT_CNT_W-1:0]   count_o
);

  opp_pkg::result_t                 entries_q [opp_pkg::OUT_DEPTH];
  logic [opp_pkg::OUT_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [opp_pkg::OUT_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [opp_pkg::OUT_CNT_W-1:0]    count_q, count_d;
  logic                             do_pop;

  assign do_pop      = pop_i && (count_q != '0);
  assign not_empty_o = (count_q != '0);
  assign head_o      = entries_q[rd_ptr_q];
  assign count_o     = count_q;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + opp_pkg::OUT_PTR_W'(push_i.num);
    rd_ptr_d = rd_ptr_q + opp_pkg::OUT_PTR_W'(do_pop);
    count_d  = count_q + opp_pkg::OUT_CNT_W'(push_i.num) - opp_pkg::OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write up to four results at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < opp_pkg::MAX_RESULTS; k++) begin
      if (opp_pkg::PUSH_W'(k) < push_i.num) begin
        entries_q[wr_ptr_q + opp_pkg::OUT_PTR_W'(k)] <= push_i.items[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= opp_pkg::OUT_CNT_W'(opp_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opp_pkg::OUT_PTR_W'(wr_ptr_q - rd_ptr_q) == opp_pkg::OUT_PTR_W'(count_q)))
    else $error("result queue pointers disagree with fill level");

  a_pop_moves_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop |=> rd_ptr_q == opp_pkg::OUT_PTR_W'($past(rd_ptr_q) + 1'b1)))
    else $error("pop did not advance the read pointer");
`endif

endmodule

// ===== rtl/oled_page_pixel_packer.sv =====
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_ready_o      | pixel_value_i, restart_i
// out     | output    | out_valid_o / out_ready_i    | out_byte_o, is_data_o, last_o,
//         |           |                              | frame_done_o
// cfg     | input     | cfg_valid_i / cfg_ready_o    | column_offset_i
//
// One pixel is accepted per cycle while in_ready_o is high; its results pass through the
// column store read, then the read-modify-write and queue push, before leaving the queue.
// Column 0 of a band's last row yields four results; the eight-entry result queue
// absorbs them, and the input stalls only while fewer than four slots remain free.
// Reset clears position, offset (to 2) and the queue; the column store has no reset.
// A stalled output only stalls the input once the queue is nearly full.
module oled_page_pixel_packer #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    pixel_value_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          is_data_o,
  output logic                          last_o,
  output logic                          frame_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [opp_pkg::OFFSET_W-1:0]  column_offset_i
);

  localparam int COL_W         = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W         = $clog2(SCREEN_ROWS);
  localparam int LAST_FULL_ROW = (SCREEN_ROWS / 8) * 8 - 1;
  localparam int SUM_W         = opp_pkg::OUT_CNT_W + 1;

  // Column store
  logic [opp_pkg::ENTRY_W-1:0]  store_mem [SCREEN_COLUMNS];
  logic [opp_pkg::ENTRY_W-1:0]  rdata_q;

  logic [opp_pkg::OFFSET_W-1:0] offset_q;
  logic [ROW_W-1:0]             row_q, row_d;
  logic [COL_W-1:0]             col_q, col_d;

  // Second stage of an item
  logic                         s1_valid_q;
  logic [ROW_W-1:0]             s1_row_q;
  logic [COL_W-1:0]             s1_col_q;
  logic                         s1_lit_q;
  logic                         s1_fwd_hit_q;
  logic [opp_pkg::ENTRY_W-1:0]  s1_fwd_data_q;

  logic                         in_accept;
  logic [ROW_W-1:0]             eff_row;
  logic [COL_W-1:0]             eff_col;
  logic [2:0]                   band_row;
  logic [opp_pkg::ENTRY_W-1:0]  rd_entry, base_entry, wr_entry;
  logic                         wr_en, emit, col_zero, done;
  logic [7:0]                   offset_byte;
  opp_pkg::result_t             data_res;
  opp_pkg::push_t               push;
  opp_pkg::result_t             head;
  logic                         fifo_not_empty;
  logic [opp_pkg::OUT_CNT_W-1:0] fifo_count;
  logic [SUM_W-1:0]             fill_sum;

  // Admit an item only if the queue can take a full burst after this cycle
  assign fill_sum    = SUM_W'(fifo_count) + SUM_W'(push.num);
  assign in_ready_o  = fill_sum <= SUM_W'(opp_pkg::OUT_DEPTH - opp_pkg::MAX_RESULTS);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Position of this item, restart first
  always_comb begin
    eff_row = restart_i ? '0 : row_q;
    eff_col = restart_i ? '0 : col_q;
    row_d   = eff_row;
    col_d   = eff_col + COL_W'(1);
    if (eff_col == COL_W'(SCREEN_COLUMNS - 1)) begin
      col_d = '0;
      row_d = (eff_row == ROW_W'(SCREEN_ROWS - 1)) ? '0 : eff_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      offset_q <= opp_pkg::OFFSET_RESET;
    end else begin
      if (in_accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (cfg_valid_i) begin
        offset_q <= column_offset_i;
      end
    end
  end

  // Modify the entry read for this item
  always_comb begin
    band_row   = s1_row_q[2:0];
    rd_entry   = s1_fwd_hit_q ? s1_fwd_data_q : rdata_q;
    base_entry = (band_row == 3'd0) ? '0 : rd_entry;
    wr_entry   = (base_entry & ~(opp_pkg::ENTRY_W'(1) << band_row))
               | (opp_pkg::ENTRY_W'(s1_lit_q) << band_row);
    wr_en      = s1_valid_q && (band_row != 3'd7);
    emit       = s1_valid_q && (band_row == 3'd7);
    col_zero   = (s1_col_q == '0);
    done       = (s1_row_q == ROW_W'(LAST_FULL_ROW))
              && (s1_col_q == COL_W'(SCREEN_COLUMNS - 1));
  end

  // Memory: write back, read for the next item
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[s1_col_q] <= wr_entry;
    end
    if (in_accept) begin
      rdata_q <= store_mem[eff_col];
    end
  end

  // Forward a write that lands on the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_row_q      <= eff_row;
      s1_col_q      <= eff_col;
      s1_lit_q      <= (pixel_value_i != 8'd0);
      s1_fwd_hit_q  <= wr_en && (s1_col_q == eff_col);
      s1_fwd_data_q <= wr_entry;
    end
  end

  // Build the results of a band's last row
  always_comb begin
    offset_byte         = {1'b0, offset_q};
    data_res.out_byte   = {s1_lit_q, rd_entry};
    data_res.is_data    = 1'b1;
    data_res.last       = 1'b1;
    data_res.frame_done = done;
    push.items          = '0;
    push.num            = '0;
    if (emit) begin
      if (col_zero) begin
        push.num                  = opp_pkg::PUSH_W'(opp_pkg::MAX_RESULTS);
        push.items[0].out_byte    = opp_pkg::CMD_PAGE_BASE + 8'(s1_row_q >> 3);
        push.items[1].out_byte    = ((offset_byte & opp_pkg::NIBBLE_HIGH) >> 4)
                                  | opp_pkg::CMD_COL_HIGH;
        push.items[2].out_byte    = offset_byte & opp_pkg::NIBBLE_LOW;
        push.items[3]             = data_res;
      end else begin
        push.num      = opp_pkg::PUSH_W'(1);
        push.items[0] = data_res;
      end
    end
  end

  opp_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (out_ready_i),
    .head_o      (head),
    .not_empty_o (fifo_not_empty),
    .count_o     (fifo_count)
  );

  assign out_valid_o  = fifo_not_empty;
  assign out_byte_o   = head.out_byte;
  assign is_data_o    = head.is_data;
  assign last_o       = head.last;
  assign frame_done_o = head.frame_done;

`ifndef SYNTHESIS
  a_restart_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && restart_i |=> s1_valid_q && (s1_row_q == '0) && (s1_col_q == '0)))
    else $error("restart did not return to row 0, column 0");

  a_forward_only_band_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_hit_q |-> s1_row_q[2:0] == 3'd0))
    else $error("forwarded entry used outside band row 0");

  a_done_is_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o |-> is_data_o && last_o))
    else $error("frame_done on a command or non-final result");

  a_room_for_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept |=> (SUM_W'(fifo_count) + SUM_W'(push.num))
                   <= SUM_W'(opp_pkg::OUT_DEPTH)))
    else $error("accepted item would overflow the result queue");
`endif

endmodule

// ===== tb/oled_page_pixel_packer_test.sv =====
`timescale 1ns / 100ps

module oled_page_pixel_packer_test;

  localparam int COLUMNS       = 128;
  localparam int ROWS          = 64;
  localparam int LAST_FULL_ROW = (ROWS / 8) * 8 - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 360;

  logic                         clk_i         = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_ready_o;
  logic [7:0]                   pixel_value   = 8'h00;
  logic                         restart       = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready     = 1'b0;
  logic [7:0]                   out_byte_o;
  logic                         is_data_o;
  logic                         last_o;
  logic                         frame_done_o;
  logic                         cfg_valid     = 1'b0;
  logic                         cfg_ready_o;
  logic [opp_pkg::OFFSET_W-1:0] column_offset = '0;

  // Shadow of the packer: band store, scan position and column offset
  logic [opp_pkg::ENTRY_W-1:0]  band_store [COLUMNS];
  logic [5:0]                   row_pos;
  logic [6:0]                   col_pos;
  logic [opp_pkg::OFFSET_W-1:0] offset_reg;

  opp_pkg::result_t expected_bytes [$];
  int               bytes_predicted = 0;
  int               mismatches      = 0;
  int               burst_left      = 0;
  int               ready_hold      = 0;
  int               ready_roll;
  opp_pkg::result_t seen;
  opp_pkg::result_t want;

  logic [7:0]                   edge_pix [8]    = '{8'h00, 8'h01, 8'h80, 8'hFF,
                                                    8'h00, 8'h7F, 8'h00, 8'hFE};
  logic [opp_pkg::OFFSET_W-1:0] offset_list [8] = '{7'd0, 7'd127, 7'h0F, 7'h70,
                                                    7'h55, 7'h2A, 7'h10, 7'd2};

  oled_page_pixel_packer #(
    .SCREEN_COLUMNS(COLUMNS),
    .SCREEN_ROWS   (ROWS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .pixel_value_i  (pixel_value),
    .restart_i      (restart),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .is_data_o      (is_data_o),
    .last_o         (last_o),
    .frame_done_o   (frame_done_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .column_offset_i(column_offset)
  );

  always #5 clk_i = ~clk_i;

  // Queue one expected byte for the display
  function automatic void queue_byte(input logic [7:0] b, input logic data,
                                     input logic done);
    opp_pkg::result_t r;
    r.out_byte   = b;
    r.is_data    = data;
    r.last       = data;
    r.frame_done = done;
    expected_bytes.push_back(r);
    bytes_predicted++;
  endfunction

  // Pack one pixel into the shadow store and predict the bytes it releases
  function automatic void pack_pixel(input logic [7:0] value, input logic rst_pos);
    logic                        lit;
    logic [2:0]                  band_row;
    logic [opp_pkg::ENTRY_W-1:0] entry;
    logic [7:0]                  x;
    lit = (value != 8'h00);
    if (rst_pos) begin
      row_pos = '0;
      col_pos = '0;
    end
    band_row = row_pos[2:0];
    if (band_row != 3'd7) begin
      // band row 0 starts a fresh entry, later rows merge into it
      entry = (band_row == 3'd0) ? '0 : band_store[col_pos];
      entry[band_row] = lit;
      band_store[col_pos] = entry;
    end else begin
      if (col_pos == 0) begin
        x = {1'b0, offset_reg};
        queue_byte(opp_pkg::CMD_PAGE_BASE + {5'd0, row_pos[5:3]}, 1'b0, 1'b0);
        queue_byte(opp_pkg::CMD_COL_HIGH | ((x & opp_pkg::NIBBLE_HIGH) >> 4), 1'b0, 1'b0);
        queue_byte(x & opp_pkg::NIBBLE_LOW, 1'b0, 1'b0);
      end
      queue_byte({lit, band_store[col_pos]}, 1'b1,
                 (row_pos == LAST_FULL_ROW) && (col_pos == COLUMNS - 1));
    end
    // advance in raster order, wrapping at the end of the frame
    if (col_pos == COLUMNS - 1) begin
      col_pos = '0;
      row_pos = (row_pos == ROWS - 1) ? '0 : row_pos + 6'd1;
    end else begin
      col_pos = col_pos + 7'd1;
    end
  endfunction

  // Mostly no gap, some short ones, a few long, and idle-free stretches
  function automatic int idle_cycles();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(30, 300);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Roughly half dark pixels, lit ones with a spread of byte values
  function automatic logic [7:0] random_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 8'h00;
    if (roll < 52) return 8'h01;
    if (roll < 59) return 8'h80;
    if (roll < 66) return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  // Offer one pixel and hold it until accepted; valid stays high afterwards
  task automatic send_pixel(input logic [7:0] value, input logic rst_pos);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    pixel_value <= value;
    restart     <= rst_pos;
    do @(posedge clk_i); while (!in_ready_o);
    pack_pixel(value, rst_pos);
  endtask

  // Drop valid, wait for every expected byte, then let the pipeline settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      mismatches++;
      expected_bytes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [opp_pkg::OFFSET_W-1:0] value);
    cfg_valid     <= 1'b1;
    column_offset <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    offset_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // One full band at the reset offset, edge pixel values in the first columns
  task automatic test_first_band();
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        send_pixel((c < 8) ? edge_pix[(r + c) % 8] : random_pixel(),
                   (r == 0) && (c == 0));
      end
    end
  endtask

  // Abandon bands part-way, once in row 2 and once inside the emitting row
  task automatic test_restart();
    repeat (300) send_pixel(random_pixel(), 1'b0);
    send_pixel(random_pixel(), 1'b1);
    repeat (7 * COLUMNS) send_pixel(random_pixel(), 1'b0);
    // hold the source back until the four bytes of column 0 are out
    drain_results();
    repeat (40) send_pixel(random_pixel(), 1'b0);
    send_pixel(random_pixel(), 1'b1);
    repeat (8 * COLUMNS - 1) send_pixel(random_pixel(), 1'b0);
  endtask

  // Whole frame, a new column offset before every band, ending in a wrap
  task automatic test_offset_frame();
    for (int band = 0; band < ROWS / 8; band++) begin
      drain_results();
      write_offset(offset_list[band % 8]);
      for (int i = 0; i < 8 * COLUMNS; i++) begin
        send_pixel(random_pixel(), (band == 0) && (i == 0));
      end
    end
  endtask

  // Long raster runs with the odd restart thrown in
  task automatic test_random_stream();
    int sent;
    int first_byte;
    sent = 0;
    drain_results();
    write_offset(opp_pkg::OFFSET_W'($urandom_range(0, 127)));
    first_byte = bytes_predicted;
    while (sent < RANDOM_ITEMS || bytes_predicted - first_byte < 48) begin
      send_pixel(random_pixel(), $urandom_range(0, 999) == 0);
      sent++;
    end
  endtask

  // Check each accepted byte, then pick the next ready pattern
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) begin
      seen = {out_byte_o, is_data_o, last_o, frame_done_o};
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h data=%b last=%b done=%b", $time,
                 seen.out_byte, seen.is_data, seen.last, seen.frame_done);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (seen.out_byte !== want.out_byte || seen.is_data !== want.is_data ||
            seen.last !== want.last || seen.frame_done !== want.frame_done) begin
          $display("%0t: expected %h data=%b last=%b done=%b, got %h data=%b last=%b done=%b",
                   $time, want.out_byte, want.is_data, want.last, want.frame_done,
                   seen.out_byte, seen.is_data, seen.last, seen.frame_done);
          mismatches++;
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(0, 8);
      end else if (ready_roll < 92) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else if (ready_roll < 97) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(5, 30);
      end else begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(50, 200);
      end
    end
  end

  initial begin
    for (int c = 0; c < COLUMNS; c++) band_store[c] = '0;
    row_pos    = '0;
    col_pos    = '0;
    offset_reg = opp_pkg::OFFSET_RESET;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_first_band();
    test_restart();
    test_offset_frame();
    test_random_stream();

    drain_results();
    if (mismatches == 0) begin
      $display("** oled_page_pixel_packer: PASSED **");
    end else begin
      $display("** oled_page_pixel_packer: FAILED **");
    end
    $finish;
  end

  // Give up well past the slowest legal run
  initial begin
    #20_000_000;
    $display("** oled_page_pixel_packer: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/opp_pkg.sv
rtl/opp_result_fifo.sv
rtl/oled_page_pixel_packer.sv
tb/oled_page_pixel_packer_test.sv
